@@ sv/jsu_pkg.sv @@
`timescale 1ns / 1ps

package jsu_pkg;

  // utf-8 lead and continuation forms
  localparam logic [7:0] UTF8_CONT_MASK = 8'b0011_1111;
  localparam logic [7:0] UTF8_CONT      = 8'b1000_0000;
  localparam logic [7:0] UTF8_LEAD2     = 8'b1100_0000;
  localparam logic [7:0] UTF8_LEAD3     = 8'b1110_0000;

  // characters that matter after a backslash
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_B      = 8'h62;
  localparam logic [7:0] CH_R      = 8'h72;
  localparam logic [7:0] CH_T      = 8'h74;
  localparam logic [7:0] CH_N      = 8'h6E;
  localparam logic [7:0] CH_U      = 8'h75;

  // control bytes produced by escapes
  localparam logic [7:0] BYTE_BS = 8'h08;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] BYTE_HT = 8'h09;
  localparam logic [7:0] BYTE_LF = 8'h0A;

  // one decoded input item, holding one to three results
  typedef struct packed {
    logic [2:0][7:0] bytes;     // bytes[0] goes out first
    logic [1:0]      cnt_m1;    // number of results minus one
    logic            has_data;  // results carry bytes
    logic            eos;       // end mark on the final result
    logic            err;       // error flag on the final result
  } jsu_entry_t;

  // hex digit check and value
  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } jsu_hex_t;

  function automatic jsu_hex_t hex_value(input logic [7:0] c);
    jsu_hex_t h;
    h.ok  = 1'b1;
    h.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      h.val = c[3:0];
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      h.val = c[3:0] + 4'd9;
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

@@ sv/jsu_front.sv @@
`timescale 1ns / 1ps

module jsu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic [7:0]         in_byte,
  input  logic               in_last_byte,
  input  logic               q_full,
  output logic               push,
  output jsu_pkg::jsu_entry_t push_entry
);

  localparam logic [2:0] PH_PLAIN = 3'd0;
  localparam logic [2:0] PH_ESC   = 3'd1;
  localparam logic [2:0] PH_HEX1  = 3'd2;
  localparam logic [2:0] PH_HEX4  = 3'd5;

  logic [2:0]  phase_r, phase_nxt;
  logic [11:0] acc_r, acc_nxt;
  logic        err_r, err_nxt;

  logic              accept;
  logic [1:0]        n;
  logic [2:0][7:0]   bytes;
  jsu_pkg::jsu_hex_t hx;
  logic [15:0]       rune;

  assign accept = in_valid && !q_full;
  assign hx     = jsu_pkg::hex_value(in_byte);
  assign rune   = {acc_r, hx.val};

  // decode one byte into up to three output bytes
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    err_nxt   = err_r;
    n         = 2'd0;
    bytes     = '0;
    if (!err_r) begin
      unique case (phase_r) inside
        PH_ESC: begin
          phase_nxt = PH_PLAIN;
          n         = 2'd1;
          unique case (in_byte)
            jsu_pkg::CH_B: bytes[0] = jsu_pkg::BYTE_BS;
            jsu_pkg::CH_R: bytes[0] = jsu_pkg::BYTE_CR;
            jsu_pkg::CH_T: bytes[0] = jsu_pkg::BYTE_HT;
            jsu_pkg::CH_N: bytes[0] = jsu_pkg::BYTE_LF;
            jsu_pkg::CH_U: begin
              phase_nxt = PH_HEX1;
              acc_nxt   = '0;
              n         = 2'd0;
            end
            default: bytes[0] = in_byte;
          endcase
        end
        [PH_HEX1:PH_HEX4]: begin
          if (!hx.ok) begin
            err_nxt   = 1'b1;
            phase_nxt = PH_PLAIN;
          end else if (phase_r == PH_HEX4) begin
            phase_nxt = PH_PLAIN;
            acc_nxt   = rune[11:0];
            if (rune[15:7] == '0) begin
              n        = 2'd1;
              bytes[0] = rune[7:0];
            end else if (rune[15:11] == '0) begin
              n        = 2'd2;
              bytes[0] = jsu_pkg::UTF8_LEAD2 | {3'b000, rune[10:6]};
              bytes[1] = jsu_pkg::UTF8_CONT | ({2'b00, rune[5:0]} & jsu_pkg::UTF8_CONT_MASK);
            end else begin
              n        = 2'd3;
              bytes[0] = jsu_pkg::UTF8_LEAD3 | {4'b0000, rune[15:12]};
              bytes[1] = jsu_pkg::UTF8_CONT | ({2'b00, rune[11:6]} & jsu_pkg::UTF8_CONT_MASK);
              bytes[2] = jsu_pkg::UTF8_CONT | ({2'b00, rune[5:0]} & jsu_pkg::UTF8_CONT_MASK);
            end
          end else begin
            acc_nxt   = rune[11:0];
            phase_nxt = phase_r + 3'd1;
          end
        end
        default: begin
          phase_nxt = PH_PLAIN;
          if (in_byte == jsu_pkg::CH_BSLASH) begin
            phase_nxt = PH_ESC;
          end else begin
            n        = 2'd1;
            bytes[0] = in_byte;
          end
        end
      endcase
    end

    // end of string: an open escape is an error, an entry is always pushed, clear state
    push_entry.bytes    = bytes;
    push_entry.has_data = (n != 2'd0);
    push_entry.cnt_m1   = (n == 2'd0) ? 2'd0 : n - 2'd1;
    push_entry.eos      = in_last_byte;
    push_entry.err      = 1'b0;
    if (in_last_byte) begin
      push_entry.err = err_nxt || (phase_nxt != PH_PLAIN);
      phase_nxt      = PH_PLAIN;
      acc_nxt        = '0;
      err_nxt        = 1'b0;
    end
  end

  assign push = accept && (push_entry.has_data || in_last_byte);

  // escape state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PLAIN;
      acc_r   <= '0;
      err_r   <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      acc_r   <= acc_nxt;
      err_r   <= err_nxt;
    end
  end

endmodule

@@ sv/jsu_queue.sv @@
`timescale 1ns / 1ps

module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  jsu_pkg::jsu_entry_t push_entry,
  output logic                full,
  input  logic                pop,
  output jsu_pkg::jsu_entry_t head,
  output logic                empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

  jsu_pkg::jsu_entry_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full  = (cnt_r == FULL_CNT);
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rd_ptr_r];

  // pointer and fill count
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == LAST_PTR) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == LAST_PTR) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

@@ sv/jsu_back.sv @@
`timescale 1ns / 1ps

module jsu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  jsu_pkg::jsu_entry_t head,
  input  logic                empty,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [7:0]          out_byte,
  output logic                out_byte_valid,
  output logic                out_end_of_string,
  output logic                out_decode_error
);

  logic [1:0] k_r, k_nxt;
  logic       valid_r, valid_nxt;
  logic [7:0] byte_r;
  logic       bv_r, eos_r, err_r;

  logic take, final_res;

  assign take      = (!valid_r || !out_stall) && !empty;
  assign final_res = (k_r == head.cnt_m1);
  assign pop       = take && final_res;

  // walk through the results of the head entry
  always_comb begin
    k_nxt     = k_r;
    valid_nxt = valid_r && out_stall;
    if (take) begin
      valid_nxt = 1'b1;
      k_nxt     = final_res ? 2'd0 : k_r + 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      k_r     <= '0;
      valid_r <= 1'b0;
    end else begin
      k_r     <= k_nxt;
      valid_r <= valid_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (take) begin
      byte_r <= head.has_data ? head.bytes[k_r] : 8'h00;
      bv_r   <= head.has_data;
      eos_r  <= final_res && head.eos;
      err_r  <= final_res && head.eos && head.err;
    end
  end

  assign out_valid         = valid_r;
  assign out_byte          = byte_r;
  assign out_byte_valid    = bv_r;
  assign out_end_of_string = eos_r;
  assign out_decode_error  = err_r;

endmodule

@@ sv/json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps

// channel   handshake             payload
// in        in_valid / in_stall   in_byte[7:0], in_last_byte
// out       out_valid / out_stall out_byte[7:0], out_byte_valid,
//                                 out_end_of_string, out_decode_error
//
// one input byte per cycle while in_stall is low, one result per cycle while
// out_stall is low; a u escape yields up to three results, so the output side
// (one result a cycle) sets the rate. an input byte is decoded into the queue,
// then its first result goes to the output register. reset is synchronous,
// active low, and empties the queue. in_stall rises only while the entry queue
// is full; out_stall holds the output register and the queue absorbs the difference.

module json_string_unescape_utf8 #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_last_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_byte_valid,
  output logic       out_end_of_string,
  output logic       out_decode_error
);

  jsu_pkg::jsu_entry_t push_entry, head;
  logic push, pop, q_full, q_empty;

  assign in_stall = q_full;

  // escape decoder
  jsu_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_byte      (in_byte),
    .in_last_byte (in_last_byte),
    .q_full       (q_full),
    .push         (push),
    .push_entry   (push_entry)
  );

  // decoded entries between the two sides
  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head),
    .empty      (q_empty)
  );

  // result serializer
  jsu_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .head              (head),
    .empty             (q_empty),
    .pop               (pop),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_string (out_end_of_string),
    .out_decode_error  (out_decode_error)
  );

endmodule

@@ dv/tb_json_string_unescape_utf8.sv @@
`timescale 1ns / 1ps

module tb_json_string_unescape_utf8;

  // escape phases of the decoder
  localparam logic [2:0] PH_TEXT = 3'd0;
  localparam logic [2:0] PH_ESC  = 3'd1;
  localparam logic [2:0] PH_HEX1 = 3'd2;
  localparam logic [2:0] PH_HEX4 = 3'd5;

  // characters not in the package
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_SLASH = 8'h2F;

  localparam int RANDOM_BYTES = 160;

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       eos;
    logic       err;
  } decoded_t;

  logic       clk = 1'b0;
  logic       rst_n = 1'b0;
  logic       in_valid = 1'b0;
  logic       in_stall;
  logic [7:0] in_byte = 8'h00;
  logic       in_last_byte = 1'b0;
  logic       out_valid;
  logic       out_stall = 1'b0;
  logic [7:0] out_byte;
  logic       out_byte_valid;
  logic       out_end_of_string;
  logic       out_decode_error;

  // decoder state mirrored by the testbench
  logic [2:0]  esc_phase = PH_TEXT;
  logic [15:0] rune_acc = 16'h0000;
  logic        err_seen = 1'b0;

  decoded_t   decoded_q[$];
  logic [7:0] str_q[$];

  int fail_count = 0;
  int n_strings = 0;
  int n_err_strings = 0;
  int n_bytes = 0;
  int n_results = 0;
  int burst_left = 4;
  int stall_left = 0;
  int stall_mode = 0;

  json_string_unescape_utf8 u_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_byte           (in_byte),
    .in_last_byte      (in_last_byte),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_byte          (out_byte),
    .out_byte_valid    (out_byte_valid),
    .out_end_of_string (out_end_of_string),
    .out_decode_error  (out_decode_error)
  );

  always #2 clk = ~clk;

  function automatic int hex_digit(input logic [7:0] c);
    if (c >= 8'h30 && c <= 8'h39) return int'(c) - 8'h30;
    if (c >= 8'h61 && c <= 8'h66) return int'(c) - 8'h61 + 10;
    if (c >= 8'h41 && c <= 8'h46) return int'(c) - 8'h41 + 10;
    return -1;
  endfunction

  // hex digit character, random letter case
  function automatic logic [7:0] hex_char(input logic [3:0] v);
    if (v < 4'd10) return 8'h30 + 8'(v);
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'(v) - 8'd10;
  endfunction

  // decode one accepted byte and queue the bytes it should produce
  task automatic predict_decode(input logic [7:0] c, input logic last);
    decoded_t res [3];
    int       n;
    int       h;
    n = 0;
    if (!err_seen) begin
      if (esc_phase == PH_ESC) begin
        esc_phase = PH_TEXT;
        case (c)
          jsu_pkg::CH_B: begin res[n] = '{jsu_pkg::BYTE_BS, 1'b1, 1'b0, 1'b0}; n++; end
          jsu_pkg::CH_R: begin res[n] = '{jsu_pkg::BYTE_CR, 1'b1, 1'b0, 1'b0}; n++; end
          jsu_pkg::CH_T: begin res[n] = '{jsu_pkg::BYTE_HT, 1'b1, 1'b0, 1'b0}; n++; end
          jsu_pkg::CH_N: begin res[n] = '{jsu_pkg::BYTE_LF, 1'b1, 1'b0, 1'b0}; n++; end
          jsu_pkg::CH_U: begin esc_phase = PH_HEX1; rune_acc = 16'h0000; end
          default:       begin res[n] = '{c, 1'b1, 1'b0, 1'b0}; n++; end
        endcase
      end else if (esc_phase >= PH_HEX1 && esc_phase <= PH_HEX4) begin
        h = hex_digit(c);
        if (h < 0) begin
          err_seen = 1'b1;
          esc_phase = PH_TEXT;
        end else begin
          rune_acc = {rune_acc[11:0], 4'(h)};
          if (esc_phase == PH_HEX4) begin
            esc_phase = PH_TEXT;
            // utf-8 form by code point range
            if (rune_acc < 16'h0080) begin
              res[0] = '{rune_acc[7:0], 1'b1, 1'b0, 1'b0};
              n = 1;
            end else if (rune_acc < 16'h0800) begin
              res[0] = '{jsu_pkg::UTF8_LEAD2 | 8'(rune_acc >> 6), 1'b1, 1'b0, 1'b0};
              res[1] = '{jsu_pkg::UTF8_CONT | (8'(rune_acc) & jsu_pkg::UTF8_CONT_MASK),
                         1'b1, 1'b0, 1'b0};
              n = 2;
            end else begin
              res[0] = '{jsu_pkg::UTF8_LEAD3 | 8'(rune_acc >> 12), 1'b1, 1'b0, 1'b0};
              res[1] = '{jsu_pkg::UTF8_CONT | (8'(rune_acc >> 6) & jsu_pkg::UTF8_CONT_MASK),
                         1'b1, 1'b0, 1'b0};
              res[2] = '{jsu_pkg::UTF8_CONT | (8'(rune_acc) & jsu_pkg::UTF8_CONT_MASK),
                         1'b1, 1'b0, 1'b0};
              n = 3;
            end
          end else begin
            esc_phase = esc_phase + 3'd1;
          end
        end
      end else begin
        esc_phase = PH_TEXT;
        if (c == jsu_pkg::CH_BSLASH) esc_phase = PH_ESC;
        else begin res[n] = '{c, 1'b1, 1'b0, 1'b0}; n++; end
      end
    end
    // end of string: open escape is an error, end mark on the final byte
    if (last) begin
      if (esc_phase != PH_TEXT) err_seen = 1'b1;
      if (n == 0) begin
        res[0] = '{8'h00, 1'b0, 1'b0, 1'b0};
        n = 1;
      end
      res[n-1].eos = 1'b1;
      res[n-1].err = err_seen;
      if (err_seen) n_err_strings++;
      esc_phase = PH_TEXT;
      rune_acc = 16'h0000;
      err_seen = 1'b0;
    end
    for (int i = 0; i < n; i++) decoded_q.push_back(res[i]);
  endtask

  // one item on the input channel, then a gap when the burst runs out
  task automatic send_byte(input logic [7:0] b, input logic last);
    int gap;
    in_valid <= 1'b1;
    in_byte <= b;
    in_last_byte <= last;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_decode(b, last);
    n_bytes++;
    burst_left--;
    if (burst_left <= 0) begin
      gap = $urandom_range(1, 6);
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 8);
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) str_q.push_back(s[i]);
  endtask

  // send the built-up string with the end mark on its final byte
  task automatic send_string();
    for (int i = 0; i < str_q.size(); i++) send_byte(str_q[i], i == str_q.size() - 1);
    str_q.delete();
    n_strings++;
  endtask

  task automatic test_plain_bytes();
    str_q = '{8'h00, 8'hFF, 8'h7F, 8'h80};
    send_string();
    add_text("A");
    send_string();
  endtask

  task automatic test_simple_escapes();
    add_text("\\b\\r\\t\\n\\\\\\\"\\/");
    str_q.push_back(jsu_pkg::CH_BSLASH);
    str_q.push_back(8'hFF);
    str_q.push_back(jsu_pkg::CH_BSLASH);
    str_q.push_back(8'h00);
    send_string();
  endtask

  task automatic test_unicode_escapes();
    // range edges of the one, two and three byte forms
    add_text("\\u0000\\u007F\\u0080\\u07FF\\u0800");
    send_string();
    add_text("\\uD83d\\uFFFF");
    send_string();
  endtask

  task automatic test_decode_errors();
    // bad digit, then the rest of the string is dropped
    add_text("\\u1Zab\\n");
    send_string();
    // clean string right after an error
    add_text("x");
    send_string();
    // backslash as the last byte
    add_text("a\\");
    send_string();
    // escape cut off after two digits
    add_text("\\u12");
    send_string();
    // bad digit on the last byte
    add_text("\\uabcG");
    send_string();
  endtask

  // random strings, mostly well formed with a share of broken escapes
  task automatic test_random_strings();
    int         start;
    int         ntok;
    int         kind;
    int         k;
    logic [7:0] c;
    logic [15:0] cp;
    logic [15:0] edges [8];
    logic [7:0] esc_chars [7];
    edges = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF, 16'h0800, 16'hFFFF, 16'hD800, 16'hDFFF};
    esc_chars = '{jsu_pkg::CH_B, jsu_pkg::CH_R, jsu_pkg::CH_T, jsu_pkg::CH_N,
                  jsu_pkg::CH_BSLASH, CH_QUOTE, CH_SLASH};
    start = n_bytes;
    while (n_bytes - start < RANDOM_BYTES) begin
      ntok = $urandom_range(1, 10);
      for (int t = 0; t < ntok; t++) begin
        kind = $urandom_range(0, 99);
        if (kind < 45) begin
          do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CH_BSLASH);
          str_q.push_back(c);
        end else if (kind < 65) begin
          str_q.push_back(jsu_pkg::CH_BSLASH);
          if ($urandom_range(0, 4) == 0) begin
            do c = 8'($urandom_range(0, 255)); while (c == jsu_pkg::CH_U);
            str_q.push_back(c);
          end else begin
            str_q.push_back(esc_chars[$urandom_range(0, 6)]);
          end
        end else if (kind < 90) begin
          case ($urandom_range(0, 3))
            0:       cp = 16'($urandom_range(16'h0000, 16'h007F));
            1:       cp = 16'($urandom_range(16'h0080, 16'h07FF));
            2:       cp = 16'($urandom_range(16'h0800, 16'hFFFF));
            default: cp = edges[$urandom_range(0, 7)];
          endcase
          add_text("\\u");
          for (int d = 3; d >= 0; d--) str_q.push_back(hex_char(cp[d*4 +: 4]));
        end else begin
          k = $urandom_range(0, 3);
          case ($urandom_range(0, 2))
            0: begin
              // bad digit inside a u escape
              add_text("\\u");
              for (int d = 0; d < k; d++) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
              do c = 8'($urandom_range(0, 255)); while (hex_digit(c) >= 0);
              str_q.push_back(c);
            end
            1: begin
              // u escape cut off by the end of the string
              add_text("\\u");
              for (int d = 0; d < k; d++) str_q.push_back(hex_char(4'($urandom_range(0, 15))));
              t = ntok;
            end
            default: begin
              str_q.push_back(jsu_pkg::CH_BSLASH);
              t = ntok;
            end
          endcase
        end
      end
      send_string();
    end
  endtask

  // receiver stall pattern, changing mode each time stall_left runs out
  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= $urandom_range(0, 3);
      stall_left <= $urandom_range(32, 256);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      0:       out_stall <= 1'b0;
      1:       out_stall <= ($urandom_range(0, 3) == 0);
      2:       out_stall <= ($urandom_range(0, 3) != 0);
      default: out_stall <= (stall_left % 16 < 6);
    endcase
  end

  // compare each accepted result with the oldest expected byte
  always @(posedge clk) begin
    decoded_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      n_results++;
      if (decoded_q.size() == 0) begin
        $error("unexpected result: out_byte %h, byte_valid %b, eos %b, error %b",
               out_byte, out_byte_valid, out_end_of_string, out_decode_error);
        fail_count++;
      end else begin
        exp_res = decoded_q.pop_front();
        if (out_byte !== exp_res.data) begin
          $error("out_byte: expected %h, got %h", exp_res.data, out_byte);
          fail_count++;
        end
        if (out_byte_valid !== exp_res.valid) begin
          $error("out_byte_valid: expected %b, got %b", exp_res.valid, out_byte_valid);
          fail_count++;
        end
        if (out_end_of_string !== exp_res.eos) begin
          $error("out_end_of_string: expected %b, got %b", exp_res.eos, out_end_of_string);
          fail_count++;
        end
        if (out_decode_error !== exp_res.err) begin
          $error("out_decode_error: expected %b, got %b", exp_res.err, out_decode_error);
          fail_count++;
        end
      end
    end
  end

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_plain_bytes();
    test_simple_escapes();
    test_unicode_escapes();
    test_decode_errors();
    test_random_strings();
    in_valid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("covered %0d strings (%0d with decode errors), %0d input bytes, %0d results",
             n_strings, n_err_strings, n_bytes, n_results);
    $display("escapes: simple, u escapes over 1/2/3 byte forms, bad and cut-off escapes");
    if (fail_count == 0 && decoded_q.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // watchdog
  initial begin
    #2000000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

@@ sim.f @@
sv/jsu_pkg.sv
sv/jsu_front.sv
sv/jsu_queue.sv
sv/jsu_back.sv
sv/json_string_unescape_utf8.sv
dv/tb_json_string_unescape_utf8.sv
